// File: design/pdd_pkg.sv
// Shared types, register codes and fixed-point helpers for the pixel deprojection block.
`default_nettype none

package pdd_pkg;

    // Q4.28 fraction bits and the output fraction bits.
    localparam int QFRAC    = 28;
    localparam int OUT_FRAC = 8;
    localparam int OUT_SHR  = QFRAC - OUT_FRAC;

    // One in Q4.28.
    localparam logic signed [31:0] Q_ONE = 32'sh1000_0000;

    // Reset value of a reciprocal focal length (1.0 in Q2.30).
    localparam logic [31:0] INV_FOCAL_RESET = 32'h4000_0000;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_PP  = 3'd0;
    localparam logic [2:0] REG_IFX = 3'd1;
    localparam logic [2:0] REG_IFY = 3'd2;
    localparam logic [2:0] REG_K1  = 3'd3;
    localparam logic [2:0] REG_K2  = 3'd4;
    localparam logic [2:0] REG_P1  = 3'd5;
    localparam logic [2:0] REG_P2  = 3'd6;
    localparam logic [2:0] REG_K3  = 3'd7;

    // Camera model as seen by the datapath.
    typedef struct packed {
        logic [15:0]        cx;
        logic [15:0]        cy;
        logic [31:0]        ifx;
        logic [31:0]        ify;
        logic signed [31:0] k1;
        logic signed [31:0] k2;
        logic signed [31:0] p1;
        logic signed [31:0] p2;
        logic signed [31:0] k3;
    } t_cfg;

    // A clipped Q4.28 value and whether clipping happened.
    typedef struct packed {
        logic               sat;
        logic signed [31:0] val;
    } t_q;

    // One finished point.
    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic [15:0]        z;
        logic               sat;
    } t_res;

    // Clip a wide signed value to the signed 32-bit range.
    function automatic t_q clip48(input logic signed [47:0] v);
        t_q q;
        q.sat = (v[47:31] != {17{v[31]}});
        if (q.sat) begin
            q.val = v[47] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
            q.val = v[31:0];
        end
        return q;
    endfunction

    // Round a Q8.56 product back to Q4.28 (half up) and clip.
    function automatic t_q qmul_rnd(input logic signed [63:0] p);
        logic signed [64:0] t;
        t = {p[63], p} + (65'sd1 <<< (QFRAC - 1));
        return clip48({{11{t[64]}}, t[64:QFRAC]});
    endfunction

    // Round the normalization product from 34 to 28 fraction bits and clip.
    function automatic t_q norm_rnd(input logic signed [50:0] p);
        logic signed [51:0] t;
        t = {p[50], p} + 52'sd32;
        return clip48({{2{t[51]}}, t[51:6]});
    endfunction

    // Round depth times a Q4.28 value to 8 fraction bits and clip.
    function automatic t_q out_rnd(input logic signed [48:0] p);
        logic signed [49:0] t;
        t = {p[48], p} + (50'sd1 <<< (OUT_SHR - 1));
        return clip48({{18{t[49]}}, t[49:OUT_SHR]});
    endfunction

endpackage

`default_nettype wire

// File: design/pdd_regs.sv
// Configuration register file with its APB-style access port.
`default_nettype none

module pdd_regs (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [4:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic [31:0]        prdata,
    output pdd_pkg::t_cfg      o_cfg
);

    logic [31:0] r_pp;
    logic [31:0] r_ifx;
    logic [31:0] r_ify;
    logic [31:0] r_k1;
    logic [31:0] r_k2;
    logic [31:0] r_p1;
    logic [31:0] r_p2;
    logic [31:0] r_k3;
    logic        wr_en;
    logic [2:0]  idx;

    assign wr_en = psel && penable && pwrite;
    assign idx   = paddr[4:2];

    // Register writes on the access cycle of a write transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pp  <= '0;
            r_ifx <= pdd_pkg::INV_FOCAL_RESET;
            r_ify <= pdd_pkg::INV_FOCAL_RESET;
            r_k1  <= '0;
            r_k2  <= '0;
            r_p1  <= '0;
            r_p2  <= '0;
            r_k3  <= '0;
        end else if (wr_en) begin
            unique case (idx)
                pdd_pkg::REG_PP:  r_pp  <= pwdata;
                pdd_pkg::REG_IFX: r_ifx <= pwdata;
                pdd_pkg::REG_IFY: r_ify <= pwdata;
                pdd_pkg::REG_K1:  r_k1  <= pwdata;
                pdd_pkg::REG_K2:  r_k2  <= pwdata;
                pdd_pkg::REG_P1:  r_p1  <= pwdata;
                pdd_pkg::REG_P2:  r_p2  <= pwdata;
                pdd_pkg::REG_K3:  r_k3  <= pwdata;
                default: ;
            endcase
        end
    end

    // Read mux.
    always_comb begin
        unique case (idx)
            pdd_pkg::REG_PP:  prdata = r_pp;
            pdd_pkg::REG_IFX: prdata = r_ifx;
            pdd_pkg::REG_IFY: prdata = r_ify;
            pdd_pkg::REG_K1:  prdata = r_k1;
            pdd_pkg::REG_K2:  prdata = r_k2;
            pdd_pkg::REG_P1:  prdata = r_p1;
            pdd_pkg::REG_P2:  prdata = r_p2;
            pdd_pkg::REG_K3:  prdata = r_k3;
            default:          prdata = '0;
        endcase
    end

    // Fields as the datapath uses them.
    always_comb begin
        o_cfg.cx  = r_pp[15:0];
        o_cfg.cy  = r_pp[31:16];
        o_cfg.ifx = r_ifx;
        o_cfg.ify = r_ify;
        o_cfg.k1  = $signed(r_k1);
        o_cfg.k2  = $signed(r_k2);
        o_cfg.p1  = $signed(r_p1);
        o_cfg.p2  = $signed(r_p2);
        o_cfg.k3  = $signed(r_k3);
    end

endmodule

`default_nettype wire

// File: design/pdd_pipe.sv
// Eighteen-stage fixed-point deprojection datapath with distortion polynomial.
`default_nettype none

module pdd_pipe (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire pdd_pkg::t_cfg   i_cfg,
    input  wire logic            i_adv,
    input  wire logic            i_valid,
    input  wire logic [11:0]     i_pixel_column,
    input  wire logic [11:0]     i_pixel_row_index,
    input  wire logic [15:0]     i_depth_sample,
    output logic                 o_valid,
    output pdd_pkg::t_res        o_res
);

    localparam int NSTG = 18;

    logic [NSTG-1:0] r_vld;

    // Stage 1: pixel minus principal point, Q14.4.
    logic signed [17:0] r1_dx, r1_dy;
    logic [15:0]        r1_z;
    // Stage 2: times reciprocal focal length.
    logic signed [50:0] r2_mx, r2_my;
    logic [15:0]        r2_z;
    // Stage 3: normalized x, y.
    logic signed [31:0] r3_x, r3_y;
    logic               r3_sat;
    logic [15:0]        r3_z;
    // Stage 4: raw squares and cross product.
    logic signed [63:0] r4_pxx, r4_pyy, r4_pxy;
    logic signed [31:0] r4_x, r4_y;
    logic               r4_sat;
    logic [15:0]        r4_z;
    // Stage 5: rounded squares and cross product.
    logic signed [31:0] r5_xx, r5_yy, r5_xy, r5_x, r5_y;
    logic               r5_sat;
    logic [15:0]        r5_z;
    // Stage 6: r2 and raw tangential cross terms.
    logic signed [31:0] r6_r2, r6_xx, r6_yy, r6_x, r6_y;
    logic signed [63:0] r6_pp1xy, r6_pp2xy;
    logic               r6_sat;
    logic [15:0]        r6_z;
    // Stage 7.
    logic signed [63:0] r7_pr4, r7_pk1;
    logic signed [31:0] r7_tx, r7_ty, r7_p1xy, r7_p2xy, r7_r2, r7_x, r7_y;
    logic               r7_sat;
    logic [15:0]        r7_z;
    // Stage 8.
    logic signed [31:0] r8_r4, r8_k1r2, r8_r2, r8_p1xy, r8_p2xy, r8_x, r8_y;
    logic signed [63:0] r8_pp2tx, r8_pp1ty;
    logic               r8_sat;
    logic [15:0]        r8_z;
    // Stage 9.
    logic signed [63:0] r9_pr6, r9_pk2;
    logic signed [31:0] r9_p2tx, r9_p1ty, r9_k1r2, r9_p1xy, r9_p2xy, r9_x, r9_y;
    logic               r9_sat;
    logic [15:0]        r9_z;
    // Stage 10.
    logic signed [31:0] r10_r6, r10_k2r4, r10_k1r2;
    logic signed [31:0] r10_p2tx, r10_p1ty, r10_p1xy, r10_p2xy, r10_x, r10_y;
    logic               r10_sat;
    logic [15:0]        r10_z;
    // Stage 11.
    logic signed [63:0] r11_pk3;
    logic signed [31:0] r11_k2r4, r11_k1r2;
    logic signed [31:0] r11_p2tx, r11_p1ty, r11_p1xy, r11_p2xy, r11_x, r11_y;
    logic               r11_sat;
    logic [15:0]        r11_z;
    // Stage 12.
    logic signed [31:0] r12_k3r6, r12_k2r4, r12_k1r2;
    logic signed [31:0] r12_p2tx, r12_p1ty, r12_p1xy, r12_p2xy, r12_x, r12_y;
    logic               r12_sat;
    logic [15:0]        r12_z;
    // Stage 13: radial factor f.
    logic signed [31:0] r13_f;
    logic signed [31:0] r13_p2tx, r13_p1ty, r13_p1xy, r13_p2xy, r13_x, r13_y;
    logic               r13_sat;
    logic [15:0]        r13_z;
    // Stage 14: raw x*f, y*f.
    logic signed [63:0] r14_pxf, r14_pyf;
    logic signed [31:0] r14_p2tx, r14_p1ty, r14_p1xy, r14_p2xy;
    logic               r14_sat;
    logic [15:0]        r14_z;
    // Stage 15.
    logic signed [31:0] r15_xf, r15_yf;
    logic signed [31:0] r15_p2tx, r15_p1ty, r15_p1xy, r15_p2xy;
    logic               r15_sat;
    logic [15:0]        r15_z;
    // Stage 16: distorted ux, uy.
    logic signed [31:0] r16_ux, r16_uy;
    logic               r16_sat;
    logic [15:0]        r16_z;
    // Stage 17: raw depth products.
    logic signed [48:0] r17_mx, r17_my;
    logic               r17_sat;
    logic [15:0]        r17_z;
    // Stage 18: output point.
    pdd_pkg::t_res      r18_res;

    // Rounding and clipping results feeding the register stages that round or clip.
    pdd_pkg::t_q q3_x, q3_y;
    pdd_pkg::t_q q5_xx, q5_yy, q5_xy;
    pdd_pkg::t_q q6_r2;
    pdd_pkg::t_q q7_tx, q7_ty, q7_p1xy, q7_p2xy;
    pdd_pkg::t_q q8_r4, q8_k1r2;
    pdd_pkg::t_q q9_p2tx, q9_p1ty;
    pdd_pkg::t_q q10_r6, q10_k2r4;
    pdd_pkg::t_q q12_k3r6;
    pdd_pkg::t_q q13_f;
    pdd_pkg::t_q q15_xf, q15_yf;
    pdd_pkg::t_q q16_ux, q16_uy;
    pdd_pkg::t_q q18_px, q18_py;

    always_comb begin
        q3_x     = pdd_pkg::norm_rnd(r2_mx);
        q3_y     = pdd_pkg::norm_rnd(r2_my);
        q5_xx    = pdd_pkg::qmul_rnd(r4_pxx);
        q5_yy    = pdd_pkg::qmul_rnd(r4_pyy);
        q5_xy    = pdd_pkg::qmul_rnd(r4_pxy);
        q6_r2    = pdd_pkg::clip48(48'(r5_xx) + 48'(r5_yy));
        q7_tx    = pdd_pkg::clip48(48'(r6_r2) + 48'(r6_xx) + 48'(r6_xx));
        q7_ty    = pdd_pkg::clip48(48'(r6_r2) + 48'(r6_yy) + 48'(r6_yy));
        q7_p1xy  = pdd_pkg::qmul_rnd(r6_pp1xy);
        q7_p2xy  = pdd_pkg::qmul_rnd(r6_pp2xy);
        q8_r4    = pdd_pkg::qmul_rnd(r7_pr4);
        q8_k1r2  = pdd_pkg::qmul_rnd(r7_pk1);
        q9_p2tx  = pdd_pkg::qmul_rnd(r8_pp2tx);
        q9_p1ty  = pdd_pkg::qmul_rnd(r8_pp1ty);
        q10_r6   = pdd_pkg::qmul_rnd(r9_pr6);
        q10_k2r4 = pdd_pkg::qmul_rnd(r9_pk2);
        q12_k3r6 = pdd_pkg::qmul_rnd(r11_pk3);
        q13_f    = pdd_pkg::clip48(48'(pdd_pkg::Q_ONE) + 48'(r12_k1r2)
                                   + 48'(r12_k2r4) + 48'(r12_k3r6));
        q15_xf   = pdd_pkg::qmul_rnd(r14_pxf);
        q15_yf   = pdd_pkg::qmul_rnd(r14_pyf);
        q16_ux   = pdd_pkg::clip48(48'(r15_xf) + 48'(r15_p1xy) + 48'(r15_p1xy)
                                   + 48'(r15_p2tx));
        q16_uy   = pdd_pkg::clip48(48'(r15_yf) + 48'(r15_p2xy) + 48'(r15_p2xy)
                                   + 48'(r15_p1ty));
        q18_px   = pdd_pkg::out_rnd(r17_mx);
        q18_py   = pdd_pkg::out_rnd(r17_my);
    end

    // Valid bits move with the data whenever the pipeline advances.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_adv) begin
            r_vld <= {r_vld[NSTG-2:0], i_valid};
        end
    end

    // Payload registers; the whole pipeline holds while the output side is full.
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            // Stage 1
            r1_dx <= $signed({2'b00, i_pixel_column, 4'b0000}) - $signed({2'b00, i_cfg.cx});
            r1_dy <= $signed({2'b00, i_pixel_row_index, 4'b0000}) - $signed({2'b00, i_cfg.cy});
            r1_z  <= i_depth_sample;
            // Stage 2
            r2_mx <= r1_dx * $signed({1'b0, i_cfg.ifx});
            r2_my <= r1_dy * $signed({1'b0, i_cfg.ify});
            r2_z  <= r1_z;
            // Stage 3
            r3_x   <= q3_x.val;
            r3_y   <= q3_y.val;
            r3_sat <= q3_x.sat | q3_y.sat;
            r3_z   <= r2_z;
            // Stage 4
            r4_pxx <= r3_x * r3_x;
            r4_pyy <= r3_y * r3_y;
            r4_pxy <= r3_x * r3_y;
            r4_x   <= r3_x;
            r4_y   <= r3_y;
            r4_sat <= r3_sat;
            r4_z   <= r3_z;
            // Stage 5
            r5_xx  <= q5_xx.val;
            r5_yy  <= q5_yy.val;
            r5_xy  <= q5_xy.val;
            r5_x   <= r4_x;
            r5_y   <= r4_y;
            r5_sat <= r4_sat | q5_xx.sat | q5_yy.sat | q5_xy.sat;
            r5_z   <= r4_z;
            // Stage 6
            r6_r2    <= q6_r2.val;
            r6_xx    <= r5_xx;
            r6_yy    <= r5_yy;
            r6_pp1xy <= i_cfg.p1 * r5_xy;
            r6_pp2xy <= i_cfg.p2 * r5_xy;
            r6_x     <= r5_x;
            r6_y     <= r5_y;
            r6_sat   <= r5_sat | q6_r2.sat;
            r6_z     <= r5_z;
            // Stage 7
            r7_pr4  <= r6_r2 * r6_r2;
            r7_pk1  <= i_cfg.k1 * r6_r2;
            r7_tx   <= q7_tx.val;
            r7_ty   <= q7_ty.val;
            r7_p1xy <= q7_p1xy.val;
            r7_p2xy <= q7_p2xy.val;
            r7_r2   <= r6_r2;
            r7_x    <= r6_x;
            r7_y    <= r6_y;
            r7_sat  <= r6_sat | q7_tx.sat | q7_ty.sat | q7_p1xy.sat | q7_p2xy.sat;
            r7_z    <= r6_z;
            // Stage 8
            r8_r4    <= q8_r4.val;
            r8_k1r2  <= q8_k1r2.val;
            r8_pp2tx <= i_cfg.p2 * r7_tx;
            r8_pp1ty <= i_cfg.p1 * r7_ty;
            r8_r2    <= r7_r2;
            r8_p1xy  <= r7_p1xy;
            r8_p2xy  <= r7_p2xy;
            r8_x     <= r7_x;
            r8_y     <= r7_y;
            r8_sat   <= r7_sat | q8_r4.sat | q8_k1r2.sat;
            r8_z     <= r7_z;
            // Stage 9
            r9_pr6  <= r8_r4 * r8_r2;
            r9_pk2  <= i_cfg.k2 * r8_r4;
            r9_p2tx <= q9_p2tx.val;
            r9_p1ty <= q9_p1ty.val;
            r9_k1r2 <= r8_k1r2;
            r9_p1xy <= r8_p1xy;
            r9_p2xy <= r8_p2xy;
            r9_x    <= r8_x;
            r9_y    <= r8_y;
            r9_sat  <= r8_sat | q9_p2tx.sat | q9_p1ty.sat;
            r9_z    <= r8_z;
            // Stage 10
            r10_r6   <= q10_r6.val;
            r10_k2r4 <= q10_k2r4.val;
            r10_k1r2 <= r9_k1r2;
            r10_p2tx <= r9_p2tx;
            r10_p1ty <= r9_p1ty;
            r10_p1xy <= r9_p1xy;
            r10_p2xy <= r9_p2xy;
            r10_x    <= r9_x;
            r10_y    <= r9_y;
            r10_sat  <= r9_sat | q10_r6.sat | q10_k2r4.sat;
            r10_z    <= r9_z;
            // Stage 11
            r11_pk3  <= i_cfg.k3 * r10_r6;
            r11_k2r4 <= r10_k2r4;
            r11_k1r2 <= r10_k1r2;
            r11_p2tx <= r10_p2tx;
            r11_p1ty <= r10_p1ty;
            r11_p1xy <= r10_p1xy;
            r11_p2xy <= r10_p2xy;
            r11_x    <= r10_x;
            r11_y    <= r10_y;
            r11_sat  <= r10_sat;
            r11_z    <= r10_z;
            // Stage 12
            r12_k3r6 <= q12_k3r6.val;
            r12_k2r4 <= r11_k2r4;
            r12_k1r2 <= r11_k1r2;
            r12_p2tx <= r11_p2tx;
            r12_p1ty <= r11_p1ty;
            r12_p1xy <= r11_p1xy;
            r12_p2xy <= r11_p2xy;
            r12_x    <= r11_x;
            r12_y    <= r11_y;
            r12_sat  <= r11_sat | q12_k3r6.sat;
            r12_z    <= r11_z;
            // Stage 13
            r13_f    <= q13_f.val;
            r13_p2tx <= r12_p2tx;
            r13_p1ty <= r12_p1ty;
            r13_p1xy <= r12_p1xy;
            r13_p2xy <= r12_p2xy;
            r13_x    <= r12_x;
            r13_y    <= r12_y;
            r13_sat  <= r12_sat | q13_f.sat;
            r13_z    <= r12_z;
            // Stage 14
            r14_pxf  <= r13_x * r13_f;
            r14_pyf  <= r13_y * r13_f;
            r14_p2tx <= r13_p2tx;
            r14_p1ty <= r13_p1ty;
            r14_p1xy <= r13_p1xy;
            r14_p2xy <= r13_p2xy;
            r14_sat  <= r13_sat;
            r14_z    <= r13_z;
            // Stage 15
            r15_xf   <= q15_xf.val;
            r15_yf   <= q15_yf.val;
            r15_p2tx <= r14_p2tx;
            r15_p1ty <= r14_p1ty;
            r15_p1xy <= r14_p1xy;
            r15_p2xy <= r14_p2xy;
            r15_sat  <= r14_sat | q15_xf.sat | q15_yf.sat;
            r15_z    <= r14_z;
            // Stage 16
            r16_ux  <= q16_ux.val;
            r16_uy  <= q16_uy.val;
            r16_sat <= r15_sat | q16_ux.sat | q16_uy.sat;
            r16_z   <= r15_z;
            // Stage 17
            r17_mx  <= $signed({1'b0, r16_z}) * r16_ux;
            r17_my  <= $signed({1'b0, r16_z}) * r16_uy;
            r17_sat <= r16_sat;
            r17_z   <= r16_z;
            // Stage 18
            r18_res.px  <= q18_px.val;
            r18_res.py  <= q18_py.val;
            r18_res.z   <= r17_z;
            r18_res.sat <= r17_sat | q18_px.sat | q18_py.sat;
        end
    end

    assign o_valid = r_vld[NSTG-1];
    assign o_res   = r18_res;

endmodule

`default_nettype wire

// File: design/pdd_skid.sv
// Output register with a skid entry, giving a registered ready to the pipeline.
`default_nettype none

module pdd_skid (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire pdd_pkg::t_res   i_data,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output pdd_pkg::t_res        o_data
);

    logic          r_main_vld;
    logic          r_skid_vld;
    pdd_pkg::t_res r_main;
    pdd_pkg::t_res r_skid;
    logic          push;
    logic          take;

    assign o_ready = !r_skid_vld;
    assign push    = i_valid && !r_skid_vld;
    assign take    = r_main_vld && i_ready;

    // Occupancy: the skid entry fills only when the main entry is held.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_vld <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (take || !r_main_vld) begin
            if (r_skid_vld) begin
                r_main_vld <= 1'b1;
                r_skid_vld <= 1'b0;
            end else begin
                r_main_vld <= push;
            end
        end else if (push) begin
            r_skid_vld <= 1'b1;
        end
    end

    // Payload follows the same choices.
    always_ff @(posedge i_clk) begin
        if (take || !r_main_vld) begin
            if (r_skid_vld) begin
                r_main <= r_skid;
            end else if (push) begin
                r_main <= i_data;
            end
        end else if (push) begin
            r_skid <= i_data;
        end
    end

    assign o_valid = r_main_vld;
    assign o_data  = r_main;

endmodule

`default_nettype wire

// File: design/pixel_deproject_with_distortion_top.sv
// Top level of the pixel deprojection block with lens distortion correction.
//
//  Channel   Direction  Handshake          Payload
//  pixel     in         i_valid / o_ready  i_pixel_column, i_pixel_row_index, i_depth_sample
//  point     out        o_valid / i_ready  o_point_x, o_point_y, o_point_z, o_saturated
//  config    in         psel / penable     paddr, pwdata, prdata (pready tied high)
//
// One pixel enters per cycle while o_ready is high; each point passes through the
// 18 datapath stages and then the output register before it appears.
// Pipeline depth is set by the chain of dependent multiplies (x*x, r2*r2, r4*r2, k3*r6,
// x*f, depth*u), each followed by a rounding stage.
// Reset is synchronous and active low; it clears the valid bits and restores registers.
// o_ready comes from a register: the datapath holds as a whole only once the output
// register and its skid entry are both full.
`default_nettype none

module pixel_deproject_with_distortion_top (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // Configuration port
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [4:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    // Pixel channel
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic [11:0]        i_pixel_column,
    input  wire logic [11:0]        i_pixel_row_index,
    input  wire logic [15:0]        i_depth_sample,
    // Point channel
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic signed [31:0]      o_point_x,
    output logic signed [31:0]      o_point_y,
    output logic [15:0]             o_point_z,
    output logic                    o_saturated
);

    pdd_pkg::t_cfg cfg;
    pdd_pkg::t_res pipe_res;
    pdd_pkg::t_res out_res;
    logic          pipe_vld;
    logic          adv;

    assign pready = 1'b1;

    pdd_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .o_cfg   (cfg)
    );

    pdd_pipe u_pipe (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg             (cfg),
        .i_adv             (adv),
        .i_valid           (i_valid),
        .i_pixel_column    (i_pixel_column),
        .i_pixel_row_index (i_pixel_row_index),
        .i_depth_sample    (i_depth_sample),
        .o_valid           (pipe_vld),
        .o_res             (pipe_res)
    );

    pdd_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (pipe_vld),
        .o_ready (adv),
        .i_data  (pipe_res),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (out_res)
    );

    // The pipeline advances, and so takes a pixel transfer, whenever the skid entry is free.
    assign o_ready     = adv;
    assign o_point_x   = out_res.px;
    assign o_point_y   = out_res.py;
    assign o_point_z   = out_res.z;
    assign o_saturated = out_res.sat;

endmodule

`default_nettype wire

// File: design/pdd_checker.sv
// Port-level checker for the deprojection block, bound to its top level.
`default_nettype none

module pdd_checker (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               o_ready,
    input  wire logic               o_valid,
    input  wire logic               i_ready,
    input  wire logic signed [31:0] o_point_x,
    input  wire logic signed [31:0] o_point_y,
    input  wire logic [15:0]        o_point_z,
    input  wire logic               o_saturated
);

    // Reset empties the output side.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("point valid after reset");

    // Back-pressure on the pixel side only when a point is being held.
    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> o_valid)
        else $error("pixel side stalled with empty output");

    // A full skid stays full until the held point is taken.
    a_skid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_ready && !i_ready) |=> !o_ready)
        else $error("skid entry drained without a transfer");

    // Zero depth always lands at the origin.
    a_zero_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_point_z == 16'd0) |-> (o_point_x == 32'sd0 && o_point_y == 32'sd0))
        else $error("nonzero point for zero depth");

    // A held point keeps its x, y and saturated flag.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_point_x) && $stable(o_point_y)
                                   && $stable(o_saturated)))
        else $error("held point changed");

endmodule

bind pixel_deproject_with_distortion_top pdd_checker u_pdd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_ready     (o_ready),
    .o_valid     (o_valid),
    .i_ready     (i_ready),
    .o_point_x   (o_point_x),
    .o_point_y   (o_point_y),
    .o_point_z   (o_point_z),
    .o_saturated (o_saturated)
);

`default_nettype wire

// File: tb/testbench.sv
// Self-checking testbench for the pixel deprojection block with lens distortion correction.
`timescale 1ns / 100ps

module testbench;

    localparam int PIPE_DEPTH  = 19;
    localparam int STALL_LIMIT = 2000;
    localparam int RANDOM_ITEMS = 1650;

    // One pixel waiting to be sent.
    typedef struct packed {
        logic [11:0] col;
        logic [11:0] row;
        logic [15:0] depth;
    } t_pixel;

    // Clock, reset and block ports.
    logic               i_clk;
    logic               i_rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [4:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    wire  [31:0]        prdata;
    wire                pready;
    logic               i_valid = 1'b0;
    wire                o_ready;
    logic [11:0]        i_pixel_column = '0;
    logic [11:0]        i_pixel_row_index = '0;
    logic [15:0]        i_depth_sample = '0;
    wire                o_valid;
    logic               i_ready = 1'b0;
    wire signed [31:0]  o_point_x;
    wire signed [31:0]  o_point_y;
    wire [15:0]         o_point_z;
    wire                o_saturated;

    // Camera model mirrored from the register writes.
    pdd_pkg::t_cfg cam;
    logic          clip_hit;

    t_pixel        pixels_to_send[$];
    pdd_pkg::t_res points_expected[$];
    t_pixel        head_pixel;
    pdd_pkg::t_res want;

    int send_wait = 0;
    int send_burst = 0;
    int take_wait = 0;
    int take_burst = 0;
    int mismatch_count = 0;
    int points_seen = 0;
    int idle_cycles = 0;
    int items_queued = 0;
    int sensor_w, sensor_h, focal, style, batch;
    logic [31:0] pp_word, ifx_word, ify_word;
    logic [11:0] col;
    logic [11:0] row;
    logic [15:0] depth;

    pixel_deproject_with_distortion_top DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_pixel_column    (i_pixel_column),
        .i_pixel_row_index (i_pixel_row_index),
        .i_depth_sample    (i_depth_sample),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_point_x         (o_point_x),
        .o_point_y         (o_point_y),
        .o_point_z         (o_point_z),
        .o_saturated       (o_saturated)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Clip to the signed 32-bit range and note that clipping happened.
    function automatic longint sat32(input longint v);
        if (v > 64'sd2147483647) begin
            clip_hit = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            clip_hit = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    // Shift right by n bits, rounding half up.
    function automatic longint rnd_shr(input longint v, input int n);
        return (v + (longint'(1) <<< (n - 1))) >>> n;
    endfunction

    // Q4.28 times Q4.28, rounded back to Q4.28.
    function automatic longint qprod(input longint a, input longint b);
        return sat32(rnd_shr(a * b, pdd_pkg::QFRAC));
    endfunction

    // Expected camera-space point for one pixel under the current camera model.
    function automatic pdd_pkg::t_res deproject(input logic [11:0] pix_col,
                                                input logic [11:0] pix_row,
                                                input logic [15:0] pix_depth);
        longint x, y, xx, yy, xy, r2, r4, r6, gain, ux, uy;
        pdd_pkg::t_res pt;
        clip_hit = 1'b0;
        x = sat32(rnd_shr((longint'(pix_col) * 16 - longint'(cam.cx)) * longint'(cam.ifx), 6));
        y = sat32(rnd_shr((longint'(pix_row) * 16 - longint'(cam.cy)) * longint'(cam.ify), 6));
        xx = qprod(x, x);
        yy = qprod(y, y);
        xy = qprod(x, y);
        r2 = sat32(xx + yy);
        r4 = qprod(r2, r2);
        r6 = qprod(r4, r2);
        gain = sat32(longint'(pdd_pkg::Q_ONE) + qprod(cam.k1, r2) + qprod(cam.k2, r4)
                     + qprod(cam.k3, r6));
        ux = sat32(qprod(x, gain) + 2 * qprod(cam.p1, xy) + qprod(cam.p2, sat32(r2 + 2 * xx)));
        uy = sat32(qprod(y, gain) + 2 * qprod(cam.p2, xy) + qprod(cam.p1, sat32(r2 + 2 * yy)));
        pt.px  = 32'(sat32(rnd_shr(longint'(pix_depth) * ux,
                                   pdd_pkg::QFRAC - pdd_pkg::OUT_FRAC)));
        pt.py  = 32'(sat32(rnd_shr(longint'(pix_depth) * uy,
                                   pdd_pkg::QFRAC - pdd_pkg::OUT_FRAC)));
        pt.z   = pix_depth;
        pt.sat = clip_hit;
        return pt;
    endfunction

    // Idle cycles before the next transfer; some stretches run with none at all.
    function automatic int draw_wait(inout int burst);
        if (burst > 0) begin
            burst--;
            return 0;
        end
        if ($urandom_range(0, 24) == 0) begin
            burst = $urandom_range(20, 80);
            return 0;
        end
        if ($urandom_range(0, 2) == 0) begin
            return 0;
        end
        return $urandom_range(0, 10);
    endfunction

    // Small distortion coefficient, within a half either way.
    function automatic logic [31:0] small_coeff();
        return 32'($urandom_range(0, 32'h1000_0000)) - 32'h0800_0000;
    endfunction

    // One of the extreme register words.
    function automatic logic [31:0] corner_word();
        case ($urandom_range(0, 3))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h8000_0000;
            default: return 32'h7FFF_FFFF;
        endcase
    endfunction

    task automatic flag_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic add_pixel(input int c, input int r, input int d);
        t_pixel p;
        p.col = 12'(c);
        p.row = 12'(r);
        p.depth = 16'(d);
        pixels_to_send.insert(pixels_to_send.size(), p);
        items_queued++;
    endtask

    // Register write: setup cycle, then access cycle; the register takes the value at the end of the access cycle.
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            pdd_pkg::REG_PP: begin
                cam.cx = val[15:0];
                cam.cy = val[31:16];
            end
            pdd_pkg::REG_IFX: cam.ifx = val;
            pdd_pkg::REG_IFY: cam.ify = val;
            pdd_pkg::REG_K1:  cam.k1 = val;
            pdd_pkg::REG_K2:  cam.k2 = val;
            pdd_pkg::REG_P1:  cam.p1 = val;
            pdd_pkg::REG_P2:  cam.p2 = val;
            pdd_pkg::REG_K3:  cam.k3 = val;
            default: ;
        endcase
    endtask

    task automatic write_camera(input logic [31:0] pp, input logic [31:0] ifx,
                                input logic [31:0] ify, input logic [31:0] k1,
                                input logic [31:0] k2, input logic [31:0] p1,
                                input logic [31:0] p2, input logic [31:0] k3);
        write_reg(pdd_pkg::REG_PP, pp);
        write_reg(pdd_pkg::REG_IFX, ifx);
        write_reg(pdd_pkg::REG_IFY, ify);
        write_reg(pdd_pkg::REG_K1, k1);
        write_reg(pdd_pkg::REG_K2, k2);
        write_reg(pdd_pkg::REG_P1, p1);
        write_reg(pdd_pkg::REG_P2, p2);
        write_reg(pdd_pkg::REG_K3, k3);
    endtask

    // Sampled on the falling edge so that no transfer of this cycle is still in flight.
    task automatic wait_drained();
        @(negedge i_clk);
        while (pixels_to_send.size() != 0 || i_valid || points_expected.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    // Pixel driver: presents queued pixels and predicts each one on its transfer.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                points_expected.insert(points_expected.size(),
                                       deproject(i_pixel_column, i_pixel_row_index,
                                                 i_depth_sample));
                send_wait = draw_wait(send_burst);
            end
            if (!i_valid || o_ready) begin
                if (send_wait == 0 && pixels_to_send.size() != 0) begin
                    head_pixel = pixels_to_send.pop_front();
                    i_valid           <= 1'b1;
                    i_pixel_column    <= head_pixel.col;
                    i_pixel_row_index <= head_pixel.row;
                    i_depth_sample    <= head_pixel.depth;
                end else begin
                    i_valid <= 1'b0;
                    if (send_wait > 0) begin
                        send_wait--;
                    end
                end
            end
        end
    end

    // Point monitor: checks each transfer against the oldest prediction and stalls at random.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (points_expected.size() == 0) begin
                    flag_mismatch($sformatf("point %0d arrived with none pending", points_seen));
                end else begin
                    want = points_expected.pop_front();
                    if (o_point_x !== want.px) begin
                        flag_mismatch($sformatf("point %0d x got %h want %h",
                                                points_seen, o_point_x, want.px));
                    end
                    if (o_point_y !== want.py) begin
                        flag_mismatch($sformatf("point %0d y got %h want %h",
                                                points_seen, o_point_y, want.py));
                    end
                    if (o_point_z !== want.z) begin
                        flag_mismatch($sformatf("point %0d z got %h want %h",
                                                points_seen, o_point_z, want.z));
                    end
                    if (o_saturated !== want.sat) begin
                        flag_mismatch($sformatf("point %0d saturated got %b want %b",
                                                points_seen, o_saturated, want.sat));
                    end
                end
                points_seen++;
                take_wait = draw_wait(take_burst);
            end
            if (take_wait == 0) begin
                i_ready <= 1'b1;
            end else begin
                i_ready <= 1'b0;
                take_wait--;
            end
        end
    end

    // Watchdog: ends the run when no transfer of any kind happens for too long.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (psel && penable && pwrite)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Stimulus: directed phases, then random camera setups each with a batch of pixels.
    initial begin
        cam.cx  = '0;
        cam.cy  = '0;
        cam.ifx = pdd_pkg::INV_FOCAL_RESET;
        cam.ify = pdd_pkg::INV_FOCAL_RESET;
        cam.k1  = '0;
        cam.k2  = '0;
        cam.p1  = '0;
        cam.p2  = '0;
        cam.k3  = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset camera: unit focal scale, so anything past a few pixels clips.
        add_pixel(0, 0, 0);
        add_pixel(0, 0, 65535);
        add_pixel(4095, 4095, 65535);
        add_pixel(4095, 0, 1);
        add_pixel(0, 4095, 1);
        add_pixel(1, 1, 65535);
        add_pixel(0, 0, 1);
        wait_drained();

        // A plausible VGA camera with mild distortion.
        write_camera({16'd3840, 16'd5120}, 32'd2147484, 32'd2147484, 32'd26843546,
                     -32'sd13421773, 32'd268435, -32'sd536871, 32'd2684355);
        add_pixel(320, 240, 1000);
        add_pixel(0, 0, 65535);
        add_pixel(639, 479, 65535);
        add_pixel(4095, 4095, 65535);
        add_pixel(100, 400, 0);
        wait_drained();

        // Coefficients at their extremes.
        write_camera({16'd3840, 16'd5120}, 32'd5368709, 32'd5368709, 32'h7FFF_FFFF,
                     32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        add_pixel(320, 240, 65535);
        add_pixel(0, 0, 65535);
        add_pixel(639, 479, 65535);
        add_pixel(400, 300, 1000);
        wait_drained();

        // Zero and full-scale reciprocal focal lengths, principal point at its extremes.
        write_camera(32'h0000_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 32'h0,
                     32'h0);
        add_pixel(4095, 0, 65535);
        add_pixel(0, 4095, 65535);
        add_pixel(4095, 4095, 1);
        wait_drained();
        write_reg(pdd_pkg::REG_IFX, 32'hFFFF_FFFF);
        write_reg(pdd_pkg::REG_IFY, 32'h0000_0000);
        add_pixel(0, 4095, 65535);
        add_pixel(4095, 0, 65535);
        wait_drained();

        items_queued = 0;
        while (items_queued < RANDOM_ITEMS) begin
            sensor_w = $urandom_range(16, 4096);
            sensor_h = $urandom_range(16, 4096);
            focal    = $urandom_range(sensor_w / 3 + 8, 2 * sensor_w + 8);
            pp_word  = {16'($urandom_range(0, sensor_h * 16 - 1)),
                        16'($urandom_range(0, sensor_w * 16 - 1))};
            ifx_word = 32'((2 ** 30) / focal);
            ify_word = 32'((2 ** 30) / (focal + $urandom_range(0, 20)));
            style    = $urandom_range(0, 7);
            case (style)
                0: write_camera($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                                $urandom, $urandom);
                1: write_camera(corner_word(), corner_word(), corner_word(), corner_word(),
                                corner_word(), corner_word(), corner_word(), corner_word());
                2: write_camera(pp_word, ifx_word, ify_word, 32'h0, 32'h0, 32'h0, 32'h0,
                                32'h0);
                default: write_camera(pp_word, ifx_word, ify_word, small_coeff(),
                                      small_coeff(), small_coeff(), small_coeff(),
                                      small_coeff());
            endcase

            // Mostly pixels inside the sensor, some anywhere in the field range.
            batch = $urandom_range(40, 160);
            for (int n = 0; n < batch; n++) begin
                if ($urandom_range(0, 9) == 0) begin
                    col = 12'($urandom);
                    row = 12'($urandom);
                end else begin
                    col = 12'($urandom_range(0, sensor_w - 1));
                    row = 12'($urandom_range(0, sensor_h - 1));
                end
                case ($urandom_range(0, 19))
                    0: depth = 16'h0000;
                    1: depth = 16'hFFFF;
                    default: depth = ($urandom_range(0, 1) == 0) ?
                                     16'($urandom_range(100, 12000)) : 16'($urandom);
                endcase
                add_pixel(col, row, depth);
            end
            wait_drained();
        end

        repeat (2 * PIPE_DEPTH) @(posedge i_clk);
        if (points_expected.size() != 0) begin
            flag_mismatch($sformatf("%0d points never arrived", points_expected.size()));
        end
        if (mismatch_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// File: filelist.f
design/pdd_pkg.sv
design/pdd_regs.sv
design/pdd_pipe.sv
design/pdd_skid.sv
design/pixel_deproject_with_distortion_top.sv
design/pdd_checker.sv
tb/testbench.sv
